@@ design/u8d_pkg.sv @@
// shared types and constants for the utf-8 to utf-32 stream decoder
package u8d_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CP_W    = 21;
    localparam int unsigned CNT_W   = 3;
    localparam int unsigned LEFT_W  = 2;

    // lead byte sequence lengths
    localparam logic [CNT_W-1:0] LEN_1 = 3'd1;
    localparam logic [CNT_W-1:0] LEN_2 = 3'd2;
    localparam logic [CNT_W-1:0] LEN_3 = 3'd3;
    localparam logic [CNT_W-1:0] LEN_4 = 3'd4;

    // one accepted input byte
    typedef struct packed {
        logic [BYTE_W-1:0] in_byte;
        logic              end_of_text;
    } t_in_item;

    // one decoded result, valid only when emit is set
    typedef struct packed {
        logic              emit;
        logic [CP_W-1:0]   code_point;
        logic [CNT_W-1:0]  byte_count;
    } t_result;

endpackage

@@ design/utf8_to_utf32_stream_decoder_unit.sv @@
// top level of the utf-8 to utf-32 stream decoder
// Usage:
// The input channel (i_in_valid / o_in_ready) carries one utf-8 byte per
// transfer plus an end-of-text flag marking the last byte of a string.
// The output channel (o_out_valid / i_out_ready) carries one decoded code
// point and the length of its sequence per transfer; bytes that do not
// complete a sequence, invalid bytes and zero values give no transfer.
// A byte passes an input register and the decode logic into the result
// register, which drives the outputs; a stall at the receiver can hold the
// byte in the input register before its result is registered.
// One byte is taken every cycle as long as the receiver keeps up; the
// sequence state register updated by the decode logic sets that rate.
// When the receiver stalls, the result register holds, the input register
// fills, and o_in_ready drops only when both are occupied.
// Synchronous reset clears both stage valids and the pending sequence.
module utf8_to_utf32_stream_decoder_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [u8d_pkg::BYTE_W-1:0]  i_in_byte,
    input  logic                        i_end_of_text,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [u8d_pkg::CP_W-1:0]    o_code_point,
    output logic [u8d_pkg::CNT_W-1:0]   o_byte_count
);

    u8d_pkg::t_in_item w_in_item;
    u8d_pkg::t_in_item w_stage_item;
    u8d_pkg::t_result  w_result;
    logic              w_stage_valid;
    logic              w_take;
    logic              r_out_valid;
    logic              n_out_valid;
    logic [u8d_pkg::CP_W-1:0]  r_code_point;
    logic [u8d_pkg::CNT_W-1:0] r_byte_count;
    logic              w_out_free;

    assign w_in_item.in_byte     = i_in_byte;
    assign w_in_item.end_of_text = i_end_of_text;

    // input register
    u8d_in_stage u_in_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_item     (w_in_item),
        .i_take     (w_take),
        .o_valid    (w_stage_valid),
        .o_item     (w_stage_item)
    );

    // byte moves on when the result register can take its result
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_take     = w_stage_valid && w_out_free;

    u8d_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (w_take),
        .i_item   (w_stage_item),
        .o_result (w_result)
    );

    // result register
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_out_free) begin
            n_out_valid = w_take && w_result.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && w_result.emit) begin
            r_code_point <= w_result.code_point;
            r_byte_count <= w_result.byte_count;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_code_point = r_code_point;
    assign o_byte_count = r_byte_count;

endmodule

@@ design/u8d_in_stage.sv @@
// input register stage holding one byte until the decoder takes it
module u8d_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  u8d_pkg::t_in_item i_item,
    input  logic              i_take,
    output logic              o_valid,
    output u8d_pkg::t_in_item o_item
);

    logic              r_valid;
    logic              n_valid;
    u8d_pkg::t_in_item r_item;
    logic              w_load;

    // stage is free when empty or being drained this cycle
    assign o_in_ready = !r_valid || i_take;
    assign w_load     = i_in_valid && o_in_ready;

    always_comb begin
        n_valid = r_valid;
        if (w_load) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // payload register
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

@@ design/u8d_core.sv @@
// sequence state and combinational byte decode
module u8d_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  u8d_pkg::t_in_item i_item,
    output u8d_pkg::t_result  o_result
);

    logic [u8d_pkg::LEFT_W-1:0] r_bytes_left;
    logic [u8d_pkg::LEFT_W-1:0] n_bytes_left;
    logic [u8d_pkg::CP_W-1:0]   r_partial;
    logic [u8d_pkg::CP_W-1:0]   n_partial;
    logic [u8d_pkg::CNT_W-1:0]  r_seq_len;
    logic [u8d_pkg::CNT_W-1:0]  n_seq_len;
    logic [u8d_pkg::BYTE_W-1:0] w_b;
    logic                       w_is_cont;
    logic [u8d_pkg::CP_W-1:0]   w_shifted;
    logic [u8d_pkg::LEFT_W-1:0] w_left_dec;

    assign w_b        = i_item.in_byte;
    assign w_is_cont  = (w_b[7:6] == 2'b10);
    assign w_shifted  = {r_partial[u8d_pkg::CP_W-7:0], w_b[5:0]};
    assign w_left_dec = r_bytes_left - 2'd1;

    // next state and result for the byte in the input register
    always_comb begin
        n_bytes_left        = r_bytes_left;
        n_partial           = r_partial;
        n_seq_len           = r_seq_len;
        o_result.emit       = 1'b0;
        o_result.code_point = w_shifted;
        o_result.byte_count = r_seq_len;

        if ((r_bytes_left != '0) && w_is_cont) begin
            // continuation of a pending sequence
            n_bytes_left = w_left_dec;
            if (w_left_dec == '0) begin
                o_result.emit = (w_shifted != '0);
                n_partial     = '0;
                n_seq_len     = '0;
            end else begin
                n_partial = w_shifted;
            end
        end else begin
            // new lead, dropping any cut-short sequence
            n_bytes_left = '0;
            n_partial    = '0;
            n_seq_len    = '0;
            if (!w_b[7]) begin
                o_result.emit       = (w_b != '0);
                o_result.code_point = {{(u8d_pkg::CP_W-u8d_pkg::BYTE_W){1'b0}}, w_b};
                o_result.byte_count = u8d_pkg::LEN_1;
            end else if (w_b[7:5] == 3'b110) begin
                n_bytes_left = 2'd1;
                n_seq_len    = u8d_pkg::LEN_2;
                n_partial    = {{(u8d_pkg::CP_W-5){1'b0}}, w_b[4:0]};
            end else if (w_b[7:4] == 4'b1110) begin
                n_bytes_left = 2'd2;
                n_seq_len    = u8d_pkg::LEN_3;
                n_partial    = {{(u8d_pkg::CP_W-4){1'b0}}, w_b[3:0]};
            end else if (w_b[7:3] == 5'b11110) begin
                n_bytes_left = 2'd3;
                n_seq_len    = u8d_pkg::LEN_4;
                n_partial    = {{(u8d_pkg::CP_W-3){1'b0}}, w_b[2:0]};
            end
        end

        // end of text drops whatever is left pending
        if (i_item.end_of_text) begin
            n_bytes_left = '0;
            n_partial    = '0;
            n_seq_len    = '0;
        end
    end

    // state advances only when the byte is consumed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_left <= '0;
            r_partial    <= '0;
            r_seq_len    <= '0;
        end else if (i_take) begin
            r_bytes_left <= n_bytes_left;
            r_partial    <= n_partial;
            r_seq_len    <= n_seq_len;
        end
    end

endmodule
